@@ hdl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

	// Hue count width at the input port
	localparam int HUE_WIDTH = 16;

	// Scaled hue (count * 60) and hue plus offset
	localparam int SCALE_W = HUE_WIDTH + 6;
	localparam int SUM_W   = HUE_WIDTH + 7;

	// Reduction modulo 360 by reciprocal multiply: the shift leaves the
	// rounding error below one for every sum that fits in SUM_W bits
	localparam int              RECIP_SH   = SUM_W + 9;
	localparam int              RECIP_W    = SUM_W + 1;
	localparam logic [63:0]     RECIP_FULL = ((64'd1 << RECIP_SH) + 64'd359) / 64'd360;
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_FULL[RECIP_W-1:0];
	localparam int              QUO_W      = SUM_W - 8;

	localparam int HUE_W  = 9;
	localparam int SECT_W = 3;
	localparam int FRAC_W = 6;
	localparam int PCT_W  = 7;
	localparam int LVL_W  = 8;

	// Level lane: 255*V (15 bits) times (6000 - k*S) (13 bits), then / 600000
	localparam int DIFF_W      = 13;
	localparam int PEAK_W      = 15;
	localparam int PROD_W      = PEAK_W + DIFF_W;
	localparam int LVL_SH      = PROD_W + 20;
	localparam int LVL_RECIP_W = 29;
	localparam logic [63:0] LVL_RECIP_FULL =
		((64'd1 << LVL_SH) + 64'd599999) / 64'd600000;
	localparam logic [LVL_RECIP_W-1:0] LVL_RECIP = LVL_RECIP_FULL[LVL_RECIP_W-1:0];

	localparam logic [HUE_W-1:0]  FULL_CIRCLE = 9'd360;
	localparam logic [FRAC_W-1:0] SECTOR_SPAN = 6'd60;
	localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
	localparam logic [DIFF_W-1:0] PCT_SQ_SPAN = 13'd6000;

	localparam int NSTAGE    = 8;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_OFFSET = 3'd0,
		REG_SATURATION = 3'd1,
		REG_VALUE      = 3'd2,
		REG_HUE_X60    = 3'd3
	} cfg_reg_t;

	// Hue sectors, named by the color span each covers
	typedef enum logic [SECT_W-1:0] {
		SECT_R_Y = 3'd0,
		SECT_Y_G = 3'd1,
		SECT_G_C = 3'd2,
		SECT_C_B = 3'd3,
		SECT_B_M = 3'd4,
		SECT_M_R = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue_offset;
		logic             times_sixty;
	} hue_cfg_t;

	function automatic logic [PCT_W-1:0] pct_clamp(input logic [PCT_W-1:0] p);
		return (p > PCT_MAX) ? PCT_MAX : p;
	endfunction

endpackage

@@ hdl/hsv2rgb_hue.sv @@
module hsv2rgb_hue import hsv2rgb_pkg::*; (
	input  logic                  clk,
	input  logic [3:0]            adv,
	input  hue_cfg_t              cfg,
	input  logic [HUE_WIDTH-1:0]  hue_count,
	output sector_t               sector_s4,
	output logic [FRAC_W-1:0]     frac_s4
);

	logic [SCALE_W-1:0]         scaled;
	logic [SUM_W-1:0]           sum_s1;
	logic [SUM_W+RECIP_W-1:0]   quo_prod;
	logic [QUO_W-1:0]           quo_s2;
	logic [SUM_W-1:0]           sum_s2;
	logic [SUM_W-1:0]           base;
	logic [SUM_W-1:0]           rem;
	logic [HUE_W-1:0]           hue_s3;
	sector_t                    sect;
	logic [HUE_W-1:0]           sect_start;
	logic [HUE_W-1:0]           frac_full;

	// Stage 1: count * 60 as (count << 6) - (count << 2), then add offset
	always_comb begin
		if (cfg.times_sixty) begin
			scaled = {hue_count, 6'b0} - {4'b0, hue_count, 2'b0};
		end else begin
			scaled = {6'b0, hue_count};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sum_s1 <= {1'b0, scaled} + SUM_W'(cfg.hue_offset);
		end
	end

	// Stage 2: quotient by 360 through the reciprocal
	assign quo_prod = {{RECIP_W{1'b0}}, sum_s1} * {{SUM_W{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			quo_s2 <= quo_prod[RECIP_SH +: QUO_W];
			sum_s2 <= sum_s1;
		end
	end

	// Stage 3: remainder, quotient * 360 built from shifts
	assign base = {quo_s2, 8'b0} + {2'b0, quo_s2, 6'b0}
		+ {3'b0, quo_s2, 5'b0} + {5'b0, quo_s2, 3'b0};
	assign rem  = sum_s2 - base;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			hue_s3 <= rem[HUE_W-1:0];
		end
	end

	// Stage 4: split into sector and offset within the sector
	always_comb begin
		if (hue_s3 >= 9'd300) begin
			sect       = SECT_M_R;
			sect_start = 9'd300;
		end else if (hue_s3 >= 9'd240) begin
			sect       = SECT_B_M;
			sect_start = 9'd240;
		end else if (hue_s3 >= 9'd180) begin
			sect       = SECT_C_B;
			sect_start = 9'd180;
		end else if (hue_s3 >= 9'd120) begin
			sect       = SECT_G_C;
			sect_start = 9'd120;
		end else if (hue_s3 >= 9'd60) begin
			sect       = SECT_Y_G;
			sect_start = 9'd60;
		end else begin
			sect       = SECT_R_Y;
			sect_start = 9'd0;
		end
	end

	assign frac_full = hue_s3 - sect_start;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sector_s4 <= sect;
			frac_s4   <= frac_full[FRAC_W-1:0];
		end
	end

endmodule

@@ hdl/hsv2rgb_lane.sv @@
module hsv2rgb_lane import hsv2rgb_pkg::*; (
	input  logic               clk,
	input  logic [2:0]         adv,
	input  logic [FRAC_W-1:0]  k,
	input  logic [PCT_W-1:0]   sat,
	input  logic [PEAK_W-1:0]  peak,
	output logic [LVL_W-1:0]   lvl_s7
);

	logic [DIFF_W-1:0]                ks;
	logic [DIFF_W-1:0]                diff_s5;
	logic [PROD_W-1:0]                prod_s6;
	logic [PROD_W+LVL_RECIP_W-1:0]    lvl_prod;

	// Stage 5: 6000 - k*S, never negative since k <= 60 and S <= 100
	assign ks = DIFF_W'(k) * DIFF_W'(sat);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			diff_s5 <= PCT_SQ_SPAN - ks;
		end
	end

	// Stage 6: scale by 255*V
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			prod_s6 <= PROD_W'(peak) * PROD_W'(diff_s5);
		end
	end

	// Stage 7: exact floor of the division by 600000
	assign lvl_prod = {{LVL_RECIP_W{1'b0}}, prod_s6} * {{PROD_W{1'b0}}, LVL_RECIP};

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			lvl_s7 <= lvl_prod[LVL_SH +: LVL_W];
		end
	end

endmodule

@@ hdl/hsv_to_rgb_colorizer.sv @@
// An item accepted on in_valid/in_ready passes through stages 1 to 8 and
// appears on red/green/blue with out_valid, held while out_ready is low.
// Throughput: one item per cycle while out_ready stays high; eight pipeline
// stages, each with its own valid bit, so a stall fills bubbles first and
// holds the rest. Reset (arst_n low) clears every valid bit and loads the
// registers with offset 0, saturation 100, value 100, hue multiply off.
module hsv_to_rgb_colorizer import hsv2rgb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// hue item in
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [HUE_WIDTH-1:0]  hue_count,
	// color item out
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LVL_W-1:0]      red,
	output logic [LVL_W-1:0]      green,
	output logic [LVL_W-1:0]      blue,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [HUE_W-1:0]      cfg_data
);

	logic [HUE_W-1:0]   hue_offset_q;
	logic [PCT_W-1:0]   sat_q;
	logic [PCT_W-1:0]   val_q;
	logic               x60_q;

	logic [PCT_W-1:0]   sat_c;
	logic [PCT_W-1:0]   val_c;
	logic [PEAK_W-1:0]  peak;
	hue_cfg_t           hue_cfg;

	logic [NSTAGE:1]    vld_q;
	logic [NSTAGE:1]    adv;

	sector_t            sector_s4;
	sector_t            sector_s5;
	sector_t            sector_s6;
	sector_t            sector_s7;
	logic [FRAC_W-1:0]  frac_s4;
	logic [FRAC_W-1:0]  frac_rest;

	logic [LVL_W-1:0]   lv_s7;
	logic [LVL_W-1:0]   ll_s7;
	logic [LVL_W-1:0]   lm_s7;
	logic [LVL_W-1:0]   ln_s7;

	logic [LVL_W-1:0]   red_s8;
	logic [LVL_W-1:0]   green_s8;
	logic [LVL_W-1:0]   blue_s8;

	// Register file; writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_offset_q <= '0;
			sat_q        <= PCT_MAX;
			val_q        <= PCT_MAX;
			x60_q        <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_HUE_OFFSET: hue_offset_q <= cfg_data;
				REG_SATURATION: sat_q        <= cfg_data[PCT_W-1:0];
				REG_VALUE:      val_q        <= cfg_data[PCT_W-1:0];
				REG_HUE_X60:    x60_q        <= cfg_data[0];
				default:        ; // drop writes to unknown indexes
			endcase
		end
	end

	// Percent values above 100 act as 100
	assign sat_c = pct_clamp(sat_q);
	assign val_c = pct_clamp(val_q);

	// 255*V as (V << 8) - V
	assign peak = {val_c, 8'b0} - PEAK_W'(val_c);

	assign hue_cfg.hue_offset  = hue_offset_q;
	assign hue_cfg.times_sixty = x60_q;

	// Stage advance: a stage loads when it is empty or its successor moves
	always_comb begin
		adv[NSTAGE] = !vld_q[NSTAGE] || out_ready;
		for (int i = NSTAGE - 1; i >= 1; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= NSTAGE; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Stages 1-4: hue reduction and sector split
	hsv2rgb_hue u_hue (
		.clk       (clk),
		.adv       (adv[4:1]),
		.cfg       (hue_cfg),
		.hue_count (hue_count),
		.sector_s4 (sector_s4),
		.frac_s4   (frac_s4)
	);

	assign frac_rest = SECTOR_SPAN - frac_s4;

	// Stages 5-7: one lane per channel level. The full level v is the mix
	// with no saturation term, so it shares the lane structure.
	hsv2rgb_lane u_lane_v (
		.clk    (clk),
		.adv    (adv[7:5]),
		.k      ('0),
		.sat    (sat_c),
		.peak   (peak),
		.lvl_s7 (lv_s7)
	);

	hsv2rgb_lane u_lane_l (
		.clk    (clk),
		.adv    (adv[7:5]),
		.k      (SECTOR_SPAN),
		.sat    (sat_c),
		.peak   (peak),
		.lvl_s7 (ll_s7)
	);

	hsv2rgb_lane u_lane_m (
		.clk    (clk),
		.adv    (adv[7:5]),
		.k      (frac_s4),
		.sat    (sat_c),
		.peak   (peak),
		.lvl_s7 (lm_s7)
	);

	hsv2rgb_lane u_lane_n (
		.clk    (clk),
		.adv    (adv[7:5]),
		.k      (frac_rest),
		.sat    (sat_c),
		.peak   (peak),
		.lvl_s7 (ln_s7)
	);

	// Carry the sector alongside the lanes
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			sector_s5 <= sector_s4;
		end
		if (adv[6]) begin
			sector_s6 <= sector_s5;
		end
		if (adv[7]) begin
			sector_s7 <= sector_s6;
		end
	end

	// Stage 8: six-sector assignment into the output register
	always_ff @(posedge clk) begin
		if (adv[8]) begin
			case (sector_s7)
				SECT_R_Y: begin
					red_s8   <= lv_s7;
					green_s8 <= ln_s7;
					blue_s8  <= ll_s7;
				end
				SECT_Y_G: begin
					red_s8   <= lm_s7;
					green_s8 <= lv_s7;
					blue_s8  <= ll_s7;
				end
				SECT_G_C: begin
					red_s8   <= ll_s7;
					green_s8 <= lv_s7;
					blue_s8  <= ln_s7;
				end
				SECT_C_B: begin
					red_s8   <= ll_s7;
					green_s8 <= lm_s7;
					blue_s8  <= lv_s7;
				end
				SECT_B_M: begin
					red_s8   <= ln_s7;
					green_s8 <= ll_s7;
					blue_s8  <= lv_s7;
				end
				default: begin
					red_s8   <= lv_s7;
					green_s8 <= ll_s7;
					blue_s8  <= lm_s7;
				end
			endcase
		end
	end

	assign out_valid = vld_q[NSTAGE];
	assign red       = red_s8;
	assign green     = green_s8;
	assign blue      = blue_s8;

endmodule

@@ hdl/hsv2rgb_chk.sv @@
module hsv2rgb_chk import hsv2rgb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [LVL_W-1:0]      red,
	input  logic [LVL_W-1:0]      green,
	input  logic [LVL_W-1:0]      blue
);

	logic [3:0] occ_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Items inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_fire && !out_fire) begin
			occ_q <= occ_q + 4'd1;
		end else if (out_fire && !in_fire) begin
			occ_q <= occ_q - 4'd1;
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("result changed while stalled");

	// With the output free, an accepted item reaches it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
			##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("item did not reach the output in time");

	// An empty output stage never backs up the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output stage empty");

	// No result without an item inside, and never more items than stages
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid |-> occ_q != 4'd0) && occ_q <= 4'(NSTAGE))
		else $error("item count out of range");

endmodule

bind hsv_to_rgb_colorizer hsv2rgb_chk u_hsv2rgb_chk (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import hsv2rgb_pkg::*;

	// Spare register indexes: writes there must leave the block untouched
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Scale factors of the level lanes
	localparam longint unsigned LEVEL_PEAK = 255;
	localparam longint unsigned MIX_SCALE  = 600000;

	// Hue items per random phase, and the receiver hold-off length in cycles
	localparam int PHASE_ITEMS = 235;
	localparam int NUM_PHASES  = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 16;

	typedef struct packed {
		logic [LVL_W-1:0] r;
		logic [LVL_W-1:0] g;
		logic [LVL_W-1:0] b;
	} color_t;

	// One directed row: register setting, hue item, and an optional typed-in color
	typedef struct packed {
		logic [HUE_W-1:0]     offset;
		logic [HUE_W-1:0]     sat;
		logic [HUE_W-1:0]     val;
		logic                 x60;
		logic [HUE_WIDTH-1:0] hue;
		logic                 typed;
		color_t               want;
	} stim_row_t;

	localparam int DIR_N = 23;

	// Rows 0..5 run on the reset setting and hit each sector boundary
	stim_row_t dir_rows [0:DIR_N-1] = '{
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd0,     1'b1, '{8'hFF, 8'h00, 8'h00}},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd60,    1'b1, '{8'hFF, 8'hFF, 8'h00}},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd120,   1'b1, '{8'h00, 8'hFF, 8'h00}},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd180,   1'b1, '{8'h00, 8'hFF, 8'hFF}},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd240,   1'b1, '{8'h00, 8'h00, 8'hFF}},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd300,   1'b1, '{8'hFF, 8'h00, 8'hFF}},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd359,   1'b0, '0},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'hFFFF,  1'b0, '0},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'd30,    1'b0, '0},
		// value zero: black everywhere
		'{9'd0,   9'd100,  9'd0,    1'b0, 16'd45,    1'b1, '{8'h00, 8'h00, 8'h00}},
		// saturation zero: white at full value
		'{9'd0,   9'd0,    9'd100,  1'b0, 16'd200,   1'b1, '{8'hFF, 8'hFF, 8'hFF}},
		// saturation and value above 100 clamp to 100
		'{9'd0,   9'd127,  9'd127,  1'b0, 16'd240,   1'b1, '{8'h00, 8'h00, 8'hFF}},
		'{9'd0,   9'd127,  9'd127,  1'b0, 16'd100,   1'b0, '0},
		// offset beyond a full circle
		'{9'd511, 9'd100,  9'd100,  1'b0, 16'd0,     1'b0, '0},
		'{9'd511, 9'd100,  9'd100,  1'b0, 16'hFFFF,  1'b0, '0},
		// wide hue times sixty, no overflow before the reduction
		'{9'd0,   9'd100,  9'd100,  1'b1, 16'hFFFF,  1'b0, '0},
		'{9'd0,   9'd100,  9'd100,  1'b1, 16'd1,     1'b1, '{8'hFF, 8'hFF, 8'h00}},
		'{9'd0,   9'd100,  9'd100,  1'b1, 16'd6,     1'b1, '{8'hFF, 8'h00, 8'h00}},
		'{9'd359, 9'd100,  9'd100,  1'b1, 16'hFFFF,  1'b0, '0},
		// upper data bits above the register width are dropped
		'{9'd0,   9'h1E4,  9'h1E4,  1'b0, 16'd120,   1'b1, '{8'h00, 8'hFF, 8'h00}},
		'{9'd200, 9'd50,   9'd50,   1'b0, 16'd1000,  1'b0, '0},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'h5555,  1'b0, '0},
		'{9'd0,   9'd100,  9'd100,  1'b0, 16'hAAAA,  1'b0, '0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [HUE_WIDTH-1:0] hue_count = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [LVL_W-1:0]     red;
	logic [LVL_W-1:0]     green;
	logic [LVL_W-1:0]     blue;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [HUE_W-1:0]     cfg_data  = '0;

	// Register copy kept by the bench, loaded at each accepted write
	logic [HUE_W-1:0] offset_q = '0;
	logic [PCT_W-1:0] sat_q    = PCT_MAX;
	logic [PCT_W-1:0] val_q    = PCT_MAX;
	logic             x60_q    = 1'b0;

	// Raw setting last applied by the directed walk, starts at the reset setting
	logic [HUE_W-1:0] cur_off = 9'd0;
	logic [HUE_W-1:0] cur_sat = 9'd100;
	logic [HUE_W-1:0] cur_val = 9'd100;
	logic             cur_x60 = 1'b0;

	color_t pending_colors [$];
	int     err_count  = 0;
	int     send_idle  = 0;
	int     recv_idle  = 0;
	bit     hold_req   = 1'b0;
	bit     hold_taken = 1'b0;
	int     hold_left  = 0;

	hsv_to_rgb_colorizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.hue_count (hue_count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Exact floor of 255*V*(6000 - k*S)/600000
	function automatic longint unsigned mix_level(input longint unsigned v,
			input longint unsigned ks);
		return (LEVEL_PEAK * v * (PCT_SQ_SPAN - ks)) / MIX_SCALE;
	endfunction

	// Color that the current register copy gives for one hue count
	function automatic color_t hsv_color(input logic [HUE_WIDTH-1:0] h);
		longint unsigned hv, s, v, sect, frac, lv, ll, lm, ln;
		color_t c;
		hv = h;
		if (x60_q)
			hv = hv * SECTOR_SPAN;
		hv   = (hv + offset_q) % FULL_CIRCLE;
		sect = hv / SECTOR_SPAN;
		frac = hv % SECTOR_SPAN;
		s    = (sat_q > PCT_MAX) ? PCT_MAX : sat_q;
		v    = (val_q > PCT_MAX) ? PCT_MAX : val_q;
		lv   = (LEVEL_PEAK * v) / PCT_MAX;
		ll   = mix_level(v, SECTOR_SPAN * s);
		lm   = mix_level(v, frac * s);
		ln   = mix_level(v, (SECTOR_SPAN - frac) * s);
		case (sector_t'(sect[SECT_W-1:0]))
			SECT_R_Y: c = '{lv[7:0], ln[7:0], ll[7:0]};
			SECT_Y_G: c = '{lm[7:0], lv[7:0], ll[7:0]};
			SECT_G_C: c = '{ll[7:0], lv[7:0], ln[7:0]};
			SECT_C_B: c = '{ll[7:0], lm[7:0], lv[7:0]};
			SECT_B_M: c = '{ln[7:0], ll[7:0], lv[7:0]};
			default:  c = '{lv[7:0], ll[7:0], lm[7:0]};
		endcase
		return c;
	endfunction

	task automatic report_err(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	// Offer one hue item, idle at random first, push its color on acceptance.
	// Called and returning at a rising edge.
	task automatic send_hue(input logic [HUE_WIDTH-1:0] h, input color_t want);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		hue_count <= h;
		// in_ready is stable from the falling edge to the next rising edge
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		pending_colors.push_back(want);
	endtask

	// Hold cfg_valid high into the next write; the caller drops it after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HUE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			REG_HUE_OFFSET: offset_q = data;
			REG_SATURATION: sat_q    = data[PCT_W-1:0];
			REG_VALUE:      val_q    = data[PCT_W-1:0];
			REG_HUE_X60:    x60_q    = data[0];
			default: ;
		endcase
	endtask

	// Drain the pipe, then load all four registers and poke a spare index
	task automatic apply_setting(input logic [HUE_W-1:0] off, input logic [HUE_W-1:0] sat,
			input logic [HUE_W-1:0] val, input logic x60);
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		write_reg(REG_HUE_OFFSET, off);
		write_reg(REG_SATURATION, sat);
		write_reg(REG_VALUE, val);
		write_reg(REG_HUE_X60, {8'b0, x60});
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), HUE_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, plus one long hold-off counted here
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Check each color item against the oldest expectation; it is taken at the next
	// rising edge, and valid/ready hold still from here to that edge
	always @(negedge clk) begin
		color_t exp_c;
		if (arst_n && out_valid && out_ready) begin
			if (pending_colors.size() == 0) begin
				report_err($sformatf("color %h %h %h with none expected", red, green, blue));
			end else begin
				exp_c = pending_colors.pop_front();
				if (red !== exp_c.r)
					report_err($sformatf("red %h, expected %h", red, exp_c.r));
				if (green !== exp_c.g)
					report_err($sformatf("green %h, expected %h", green, exp_c.g));
				if (blue !== exp_c.b)
					report_err($sformatf("blue %h, expected %h", blue, exp_c.b));
			end
		end
	end

	// Hard stop well past the slowest correct run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [HUE_W-1:0]     r_off, r_sat, r_val;
		logic                 r_x60;
		logic [HUE_WIDTH-1:0] h;
		stim_row_t            row;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk: sender idles 11 of 100, receiver 46 of 100
		send_idle = 11;
		recv_idle = 46;
		for (int i = 0; i < DIR_N; i++) begin
			row = dir_rows[i];
			if (row.offset != cur_off || row.sat != cur_sat || row.val != cur_val ||
					row.x60 != cur_x60) begin
				apply_setting(row.offset, row.sat, row.val, row.x60);
				cur_off = row.offset;
				cur_sat = row.sat;
				cur_val = row.val;
				cur_x60 = row.x60;
			end
			send_hue(row.hue, row.typed ? row.want : hsv_color(row.hue));
		end

		// Random phases: even ones random settings, odd ones extremes
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p / 2)
				0: begin send_idle = 11; recv_idle = 46; end
				1: begin send_idle = 46; recv_idle = 11; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			if (p % 2 == 0) begin
				r_off = HUE_W'($urandom);
				r_sat = ($urandom_range(1) != 0) ? HUE_W'($urandom_range(100)) : HUE_W'($urandom);
				r_val = ($urandom_range(1) != 0) ? HUE_W'($urandom_range(100)) : HUE_W'($urandom);
				r_x60 = 1'($urandom_range(1));
			end else if (p == 1) begin
				r_off = 9'd359; r_sat = 9'd0;   r_val = 9'd100; r_x60 = 1'b1;
			end else if (p == 3) begin
				r_off = 9'h1FF; r_sat = 9'd127; r_val = 9'd1;   r_x60 = 1'b0;
			end else begin
				r_off = 9'd0;   r_sat = 9'd100; r_val = 9'd100; r_x60 = 1'b1;
			end
			apply_setting(r_off, r_sat, r_val, r_x60);

			// Stall the receiver for a long stretch while items keep coming
			if (p == 4)
				hold_req = 1'b1;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(3))
					0, 1: h = HUE_WIDTH'($urandom);
					2:    h = HUE_WIDTH'($urandom_range(719));
					default: h = ($urandom_range(1) != 0) ? HUE_WIDTH'($urandom_range(65535, 65000))
						: HUE_WIDTH'($urandom_range(15));
				endcase
				send_hue(h, hsv_color(h));
			end
		end

		// Drop valid, wait for every color, then let the pipe run dry
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_hue.sv
hdl/hsv2rgb_lane.sv
hdl/hsv_to_rgb_colorizer.sv
hdl/hsv2rgb_chk.sv
bench/tb.sv
